/* design/nbrc_pkg.sv */
// Package holding the shared types and constants of the nearest box region classifier.
package nbrc_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int COORD_W     = 20;
    localparam int D2_W        = 48;
    localparam int ROOT_W      = 24;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_NEAREST = 3'd2;
    localparam logic [2:0] CMD_INFL    = 3'd3;
    localparam logic [2:0] CMD_NEARBY  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_DONE_BOX,
        ST_SQRT,
        ST_DIV,
        ST_EMIT,
        ST_OUT
    } state_t;

    // One squared-distance job handed to the shared distance unit.
    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic        [COORD_W-1:0] sx;
        logic        [COORD_W-1:0] sy;
        logic        [COORD_W-1:0] sz;
    } dist_req_t;

    typedef struct packed {
        logic            done;
        logic [D2_W-1:0] d2;
    } dist_rsp_t;

endpackage

/* design/nbrc_dist.sv */
// Squared half-unit distance from a point to a box, one axis at a time through one multiplier.
module nbrc_dist (
    input  logic                clk,
    input  logic                rst_n,
    input  nbrc_pkg::dist_req_t req,
    output nbrc_pkg::dist_rsp_t rsp
);

    logic [1:0]  axis_reg, axis_next;
    logic        busy_reg, busy_next;
    logic        mul_v_reg, mul_v_next;
    logic        sq_v_reg, sq_v_next;
    logic [nbrc_pkg::D2_W-1:0] sum_reg, sum_next;
    logic [22:0] gap_reg, gap_next;
    logic [45:0] sq_reg;
    logic        done_reg, done_next;

    logic signed [22:0] q, lo, hi;
    logic signed [nbrc_pkg::COORD_W-1:0] p_sel, c_sel;
    logic [nbrc_pkg::COORD_W-1:0] s_sel;

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin p_sel = req.px; c_sel = req.cx; s_sel = req.sx; end
            2'd1:    begin p_sel = req.py; c_sel = req.cy; s_sel = req.sy; end
            default: begin p_sel = req.pz; c_sel = req.cz; s_sel = req.sz; end
        endcase
        q  = 23'(p_sel) <<< 1;
        lo = (23'(c_sel) <<< 1) - $signed({3'b000, s_sel});
        hi = (23'(c_sel) <<< 1) + $signed({3'b000, s_sel});
        gap_next = 23'd0;
        if (q < lo)
            gap_next = 23'(lo - q);
        else if (q > hi)
            gap_next = 23'(q - hi);
    end

    always_comb
    begin
        axis_next  = axis_reg;
        busy_next  = busy_reg;
        mul_v_next = 1'b0;
        sq_v_next  = mul_v_reg;
        sum_next   = sum_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            axis_next = 2'd0;
            sum_next  = '0;
        end
        else if (busy_reg)
        begin
            mul_v_next = 1'b1;
            if (axis_reg == 2'd2)
                busy_next = 1'b0;
            else
                axis_next = axis_reg + 2'd1;
        end
        if (sq_v_reg)
            sum_next = sum_reg + nbrc_pkg::D2_W'(sq_reg);
        // The square of the last axis passes through gap_reg and sq_reg before it is summed.
        if (sq_v_reg && !mul_v_reg)
            done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= 2'd0;
            busy_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            sq_v_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            axis_reg  <= axis_next;
            busy_reg  <= busy_next;
            mul_v_reg <= mul_v_next;
            sq_v_reg  <= sq_v_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg <= gap_next;
        sq_reg  <= gap_reg * gap_reg;
        sum_reg <= sum_next;
    end

    assign rsp.done = done_reg;
    assign rsp.d2   = sum_reg;

endmodule

/* design/nbrc_sqrtdiv.sv */
// Shared bit-serial unit: integer square root of a squared distance, then a restoring divide.
module nbrc_sqrtdiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sqrt_start,
    input  logic                      div_start,
    input  logic [nbrc_pkg::D2_W-1:0] d2,
    input  logic [21:0]               mh,
    output logic                      done,
    output logic [16:0]               quotient
);

    // Root of a 48-bit value in 24 steps; quotient of a 40-bit numerator in 40 steps.
    logic [5:0]  step_reg, step_next;
    logic        sq_mode_reg, sq_mode_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [nbrc_pkg::D2_W-1:0] rem_reg, rem_next;
    logic [nbrc_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [nbrc_pkg::D2_W-1:0] op_reg, op_next;
    logic [39:0] num_reg, num_next;
    logic [16:0] quo_reg, quo_next;
    logic [nbrc_pkg::D2_W+1:0] trial;
    logic [40:0] drem;
    logic [21:0] diff;

    always_comb
    begin
        step_next    = step_reg;
        sq_mode_next = sq_mode_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        root_next    = root_reg;
        op_next      = op_reg;
        num_next     = num_reg;
        quo_next     = quo_reg;
        trial        = '0;
        drem         = '0;
        diff         = mh - 22'(root_reg);
        if (sqrt_start)
        begin
            busy_next = 1'b1; sq_mode_next = 1'b1; step_next = 6'd0;
            rem_next = '0; root_next = '0; op_next = d2;
        end
        else if (div_start)
        begin
            // Numerator 65536*(mh - root) against divisor mh.
            busy_next = 1'b1; sq_mode_next = 1'b0; step_next = 6'd0;
            num_next = {2'b00, diff, 16'd0};
            rem_next = '0; quo_next = '0;
        end
        else if (busy_reg)
        begin
            if (sq_mode_reg)
            begin
                trial = {rem_reg, op_reg[nbrc_pkg::D2_W-1 -: 2]};
                op_next = op_reg << 2;
                if (trial >= {root_reg, 2'b01})
                begin
                    rem_next  = nbrc_pkg::D2_W'(trial - {root_reg, 2'b01});
                    root_next = {root_reg[nbrc_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = nbrc_pkg::D2_W'(trial);
                    root_next = {root_reg[nbrc_pkg::ROOT_W-2:0], 1'b0};
                end
                if (step_reg == 6'(nbrc_pkg::ROOT_W - 1))
                begin
                    busy_next = 1'b0; done_next = 1'b1;
                end
            end
            else
            begin
                drem = {rem_reg[39:0], num_reg[39]};
                num_next = num_reg << 1;
                if (drem >= 41'(mh))
                begin
                    rem_next = nbrc_pkg::D2_W'(drem - 41'(mh));
                    quo_next = {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = nbrc_pkg::D2_W'(drem);
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                if (step_reg == 6'd39)
                begin
                    busy_next = 1'b0; done_next = 1'b1;
                end
            end
            step_next = step_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 6'd0;
            sq_mode_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            sq_mode_reg <= sq_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        op_reg   <= op_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/nearest_box_region_classifier.sv */
// Top level of the nearest box region classifier: box table, sequencer and result register.
// Clear and add pass straight from idle to the result state. A query walks the table one box
// at a time through a single squared-distance unit that handles one axis per cycle, and each
// nearby match is written out as its own result; the influence query then runs a square root
// and a division for the box it picks. Up to 16 boxes are held; clear resets only the fill
// count. Each result waits in an output register until taken, and the next command is accepted
// once the last result is gone.
module nearest_box_region_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [2:0]  region_type,
    input  logic signed [19:0] pos_x,
    input  logic signed [19:0] pos_y,
    input  logic signed [19:0] pos_z,
    input  logic [19:0] size_x,
    input  logic [19:0] size_y,
    input  logic [19:0] size_z,
    input  logic [20:0] radius,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_type,
    output logic [3:0]  region_index,
    output logic [16:0] influence,
    output logic        found,
    output logic        table_full,
    output logic        last
);

    logic signed [19:0] cen_mem [nbrc_pkg::MAX_REGIONS][3];
    logic [19:0]        siz_mem [nbrc_pkg::MAX_REGIONS][3];
    logic [2:0]         typ_mem [nbrc_pkg::MAX_REGIONS];

    nbrc_pkg::state_t state_reg, state_next;
    logic [nbrc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [19:0] blend_reg;
    logic [nbrc_pkg::CNT_W-1:0] k_reg, k_next;
    logic [2:0]  cmd_reg, typ_reg;
    logic signed [19:0] px_reg, py_reg, pz_reg;
    logic [20:0] rad_reg;
    logic        have_reg, have_next;
    logic [nbrc_pkg::D2_W-1:0] best_reg, best_next, d2_reg, d2_next;
    logic [3:0]  bi_reg, bi_next;
    logic [4:0]  nmatch_reg, nmatch_next;
    logic [21:0] mh_reg, mh_next;
    logic        pend_reg, pend_next;
    logic [3:0]  pi_reg, pi_next;
    logic        ov_reg, ov_next;
    logic [2:0]  ot_reg, ot_next;
    logic [3:0]  oi_reg, oi_next;
    logic [16:0] oinf_reg, oinf_next;
    logic        of_reg, of_next, ofull_reg, ofull_next, ol_reg, ol_next;

    nbrc_pkg::dist_req_t dreq;
    nbrc_pkg::dist_rsp_t drsp;
    logic        sq_start, dv_start, sd_done;
    logic [16:0] quo;
    logic [3:0]  kidx;
    logic [nbrc_pkg::D2_W-1:0] lim;
    logic        match;
    logic [19:0] smax;
    logic        accept;

    assign kidx   = k_reg[nbrc_pkg::IDX_W-1:0];
    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == nbrc_pkg::ST_IDLE) && !ov_reg;
    assign lim    = (nbrc_pkg::D2_W'(rad_reg) * nbrc_pkg::D2_W'(rad_reg)) << 2;
    assign smax   = (siz_mem[kidx][0] > siz_mem[kidx][1]) ? siz_mem[kidx][0] : siz_mem[kidx][1];

    always_comb
    begin
        dreq.start = (state_reg == nbrc_pkg::ST_IDLE) ? 1'b0 :
                     (state_reg == nbrc_pkg::ST_DONE_BOX) ? 1'b0 : 1'b0;
        dreq.start = 1'b0;
        dreq.px = px_reg; dreq.py = py_reg; dreq.pz = pz_reg;
        dreq.cx = cen_mem[kidx][0]; dreq.cy = cen_mem[kidx][1]; dreq.cz = cen_mem[kidx][2];
        dreq.sx = siz_mem[kidx][0]; dreq.sy = siz_mem[kidx][1]; dreq.sz = siz_mem[kidx][2];
        if (state_reg == nbrc_pkg::ST_DIST && !pend_reg)
            dreq.start = 1'b1;
    end

    nbrc_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    nbrc_sqrtdiv u_sqrtdiv (
        .clk        (clk),
        .rst_n      (rst_n),
        .sqrt_start (sq_start),
        .div_start  (dv_start),
        .d2         (d2_reg),
        .mh         (mh_reg),
        .done       (sd_done),
        .quotient   (quo)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nbrc_pkg::ST_IDLE:
                if (accept)
                begin
                    if ((command == nbrc_pkg::CMD_NEAREST || command == nbrc_pkg::CMD_INFL ||
                         command == nbrc_pkg::CMD_NEARBY) && count_reg != '0)
                        state_next = nbrc_pkg::ST_DIST;
                    else
                        state_next = nbrc_pkg::ST_OUT;
                end
            nbrc_pkg::ST_DIST:
                if (drsp.done)
                    state_next = nbrc_pkg::ST_DONE_BOX;
            nbrc_pkg::ST_DONE_BOX:
                if (cmd_reg == nbrc_pkg::CMD_INFL && match)
                    state_next = (mh_next == '0) ? nbrc_pkg::ST_OUT : nbrc_pkg::ST_SQRT;
                else if (cmd_reg == nbrc_pkg::CMD_NEARBY && match)
                    state_next = nbrc_pkg::ST_EMIT;
                else if (k_reg + 5'd1 >= count_reg)
                    state_next = nbrc_pkg::ST_OUT;
                else
                    state_next = nbrc_pkg::ST_DIST;
            nbrc_pkg::ST_SQRT:
                if (sd_done)
                    state_next = nbrc_pkg::ST_DIV;
            nbrc_pkg::ST_DIV:
                if (sd_done)
                    state_next = nbrc_pkg::ST_OUT;
            nbrc_pkg::ST_EMIT:
                if (!ov_reg)
                    state_next = (k_reg >= count_reg) ? nbrc_pkg::ST_OUT : nbrc_pkg::ST_DIST;
            nbrc_pkg::ST_OUT:
                if (!ov_reg)
                    state_next = nbrc_pkg::ST_IDLE;
            default:
                state_next = nbrc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result control.
    always_comb
    begin
        count_next = count_reg;
        k_next = k_reg;
        have_next = have_reg;
        best_next = best_reg;
        bi_next = bi_reg;
        nmatch_next = nmatch_reg;
        d2_next = d2_reg;
        mh_next = mh_reg;
        pend_next = pend_reg;
        pi_next = pi_reg;
        ov_next = ov_reg && !out_ready;
        ot_next = ot_reg; oi_next = oi_reg; oinf_next = oinf_reg;
        of_next = of_reg; ofull_next = ofull_reg; ol_next = ol_reg;
        sq_start = 1'b0;
        dv_start = 1'b0;
        match = 1'b0;
        mh_next = 22'(smax) + {1'b0, blend_reg, 1'b0};
        case (cmd_reg)
            nbrc_pkg::CMD_NEAREST: match = 1'b0;
            nbrc_pkg::CMD_INFL:
                match = (typ_mem[kidx] == typ_reg) &&
                        (d2_reg <= nbrc_pkg::D2_W'(mh_next) * nbrc_pkg::D2_W'(mh_next));
            nbrc_pkg::CMD_NEARBY: match = (d2_reg <= lim);
            default: match = 1'b0;
        endcase

        unique case (state_reg)
            nbrc_pkg::ST_IDLE:
                if (accept)
                begin
                    k_next = '0; have_next = 1'b0; nmatch_next = '0; pend_next = 1'b0;
                    best_next = '0; bi_next = '0;
                    if (command == nbrc_pkg::CMD_CLEAR)
                        count_next = '0;
                    else if (command == nbrc_pkg::CMD_ADD &&
                             count_reg < nbrc_pkg::CNT_W'(nbrc_pkg::MAX_REGIONS))
                        count_next = count_reg + 5'd1;
                end
            nbrc_pkg::ST_DIST:
            begin
                pend_next = 1'b1;
                if (drsp.done)
                begin
                    d2_next = drsp.d2;
                    pend_next = 1'b0;
                end
            end
            nbrc_pkg::ST_DONE_BOX:
            begin
                if (cmd_reg == nbrc_pkg::CMD_NEAREST && (!have_reg || d2_reg < best_reg))
                begin
                    have_next = 1'b1; best_next = d2_reg; bi_next = kidx;
                end
                if (cmd_reg == nbrc_pkg::CMD_INFL && match)
                begin
                    have_next = 1'b1; bi_next = kidx;
                    if (mh_next != '0)
                        sq_start = 1'b1;
                end
                else
                    mh_next = mh_reg;
                if (cmd_reg == nbrc_pkg::CMD_NEARBY && match)
                    pi_next = kidx;
                k_next = k_reg + 5'd1;
            end
            nbrc_pkg::ST_SQRT:
            begin
                mh_next = mh_reg;
                if (sd_done)
                    dv_start = 1'b1;
            end
            nbrc_pkg::ST_DIV:
                mh_next = mh_reg;
            nbrc_pkg::ST_EMIT:
            begin
                mh_next = mh_reg;
                if (!ov_reg)
                begin
                    // Hold the latest match; it is written out once the next one or the end is seen.
                    if (nmatch_reg != '0)
                    begin
                        ov_next = 1'b1; ot_next = typ_mem[bi_reg]; oi_next = bi_reg;
                        oinf_next = '0; of_next = 1'b1; ofull_next = 1'b0; ol_next = 1'b0;
                    end
                    bi_next = pi_reg;
                    nmatch_next = nmatch_reg + 5'd1;
                end
            end
            nbrc_pkg::ST_OUT:
            begin
                mh_next = mh_reg;
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    ot_next = '0; oi_next = '0; oinf_next = '0;
                    of_next = 1'b0; ofull_next = 1'b0; ol_next = 1'b1;
                    unique case (cmd_reg)
                        nbrc_pkg::CMD_ADD:
                        begin
                            ot_next = typ_reg;
                            if (pend_reg)
                            begin
                                oi_next = count_reg[3:0] - 4'd1; of_next = 1'b1;
                            end
                            else
                                ofull_next = 1'b1;
                        end
                        nbrc_pkg::CMD_NEAREST:
                            if (have_reg)
                            begin
                                ot_next = typ_mem[bi_reg]; oi_next = bi_reg; of_next = 1'b1;
                            end
                        nbrc_pkg::CMD_INFL:
                        begin
                            ot_next = typ_reg;
                            if (have_reg)
                            begin
                                oi_next = bi_reg; of_next = 1'b1;
                                oinf_next = (mh_reg == '0) ? 17'h10000 : quo;
                            end
                        end
                        nbrc_pkg::CMD_NEARBY:
                            if (nmatch_reg != '0)
                            begin
                                ot_next = typ_mem[bi_reg]; oi_next = bi_reg; of_next = 1'b1;
                            end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        // An add marks success in pend_reg for the following result.
        if (state_reg == nbrc_pkg::ST_IDLE && accept && command == nbrc_pkg::CMD_ADD)
            pend_next = (count_reg < nbrc_pkg::CNT_W'(nbrc_pkg::MAX_REGIONS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nbrc_pkg::ST_IDLE;
            count_reg <= '0;
            blend_reg <= 20'd5000;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
            if (cfg_we)
                blend_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command; typ_reg <= region_type;
            px_reg <= pos_x; py_reg <= pos_y; pz_reg <= pos_z; rad_reg <= radius;
            if (command == nbrc_pkg::CMD_ADD &&
                count_reg < nbrc_pkg::CNT_W'(nbrc_pkg::MAX_REGIONS))
            begin
                cen_mem[count_reg[3:0]][0] <= pos_x;
                cen_mem[count_reg[3:0]][1] <= pos_y;
                cen_mem[count_reg[3:0]][2] <= pos_z;
                siz_mem[count_reg[3:0]][0] <= size_x;
                siz_mem[count_reg[3:0]][1] <= size_y;
                siz_mem[count_reg[3:0]][2] <= size_z;
                typ_mem[count_reg[3:0]]    <= region_type;
            end
        end
        k_reg <= k_next; have_reg <= have_next; best_reg <= best_next; bi_reg <= bi_next;
        nmatch_reg <= nmatch_next; d2_reg <= d2_next; mh_reg <= mh_next;
        pi_reg <= pi_next;
        ot_reg <= ot_next; oi_reg <= oi_next; oinf_reg <= oinf_next;
        of_reg <= of_next; ofull_reg <= ofull_next; ol_reg <= ol_next;
    end

    assign out_valid    = ov_reg;
    assign result_type  = ot_reg;
    assign region_index = oi_reg;
    assign influence    = oinf_reg;
    assign found        = of_reg;
    assign table_full   = ofull_reg;
    assign last         = ol_reg;

endmodule

/* tb/nearest_box_region_classifier_test.sv */
// Self-checking testbench for the nearest box region classifier, with its own box table predictor.
`timescale 1ns / 1ps

module nearest_box_region_classifier_test;

    typedef struct {
        logic [2:0]         cmd;
        logic [2:0]         rtype;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] pz;
        logic [19:0]        sx;
        logic [19:0]        sy;
        logic [19:0]        sz;
        logic [20:0]        rad;
    } command_t;

    typedef struct {
        logic [2:0]  rtype;
        logic [3:0]  idx;
        logic [16:0] infl;
        logic        found;
        logic        full;
        logic        last;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  command = '0;
    logic [2:0]  region_type = '0;
    logic signed [19:0] pos_x = '0;
    logic signed [19:0] pos_y = '0;
    logic signed [19:0] pos_z = '0;
    logic [19:0] size_x = '0;
    logic [19:0] size_y = '0;
    logic [19:0] size_z = '0;
    logic [20:0] radius = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  result_type;
    logic [3:0]  region_index;
    logic [16:0] influence;
    logic        found;
    logic        table_full;
    logic        last;

    command_t pending_cmds[$];
    answer_t  expected_answers[$];
    int       errors = 0;
    bit       idling_on = 1'b1;
    int       long_holds_asked = 0;
    int       long_holds_done = 0;

    // Predictor copy of the box table and the blend register.
    longint   box_c[nbrc_pkg::MAX_REGIONS][3];
    longint   box_s[nbrc_pkg::MAX_REGIONS][3];
    logic [2:0] box_t[nbrc_pkg::MAX_REGIONS];
    int       box_n = 0;
    longint   blend = 5000;

    // Generator-side view of the boxes, used to aim points near them.
    longint   aim_c[$][3];
    int       gen_n = 0;

    nearest_box_region_classifier i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .region_type(region_type), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .size_x(size_x), .size_y(size_y), .size_z(size_z), .radius(radius),
        .out_valid(out_valid), .out_ready(out_ready), .result_type(result_type),
        .region_index(region_index), .influence(influence), .found(found),
        .table_full(table_full), .last(last)
    );

    always #4 clk = ~clk;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Squared distance in half-units from a point to a stored box.
    function automatic longint unsigned box_dist2(longint p[3], int k);
        longint unsigned sum;
        longint q;
        longint lo;
        longint hi;
        longint d;
        sum = 0;
        for (int a = 0; a < 3; a++)
        begin
            q  = 2 * p[a];
            lo = 2 * box_c[k][a] - box_s[k][a];
            hi = 2 * box_c[k][a] + box_s[k][a];
            d  = (q < lo) ? lo - q : (q > hi) ? q - hi : 0;
            sum += d * d;
        end
        return sum;
    endfunction

    function automatic answer_t make_answer(logic [2:0] t, logic [3:0] i, logic [16:0] f,
                                            logic fd, logic fl, logic l);
        answer_t r;
        r.rtype = t; r.idx = i; r.infl = f; r.found = fd; r.full = fl; r.last = l;
        return r;
    endfunction

    task automatic classify(command_t c);
        longint p[3];
        longint unsigned d;
        longint unsigned best;
        longint unsigned mh;
        longint unsigned lim;
        int bi;
        int n;
        bit hit;
        p[0] = longint'(c.px); p[1] = longint'(c.py); p[2] = longint'(c.pz);
        case (c.cmd)
            nbrc_pkg::CMD_CLEAR:
            begin
                box_n = 0;
                expected_answers.push_back(make_answer(0, 0, 0, 0, 0, 1));
            end
            nbrc_pkg::CMD_ADD:
            begin
                if (box_n < nbrc_pkg::MAX_REGIONS)
                begin
                    for (int a = 0; a < 3; a++)
                        box_c[box_n][a] = p[a];
                    box_s[box_n][0] = longint'(c.sx);
                    box_s[box_n][1] = longint'(c.sy);
                    box_s[box_n][2] = longint'(c.sz);
                    box_t[box_n] = c.rtype;
                    expected_answers.push_back(make_answer(c.rtype, box_n[3:0], 0, 1, 0, 1));
                    box_n++;
                end
                else
                    expected_answers.push_back(make_answer(c.rtype, 0, 0, 0, 1, 1));
            end
            nbrc_pkg::CMD_NEAREST:
            begin
                bi = -1;
                best = 0;
                for (int k = 0; k < box_n; k++)
                begin
                    d = box_dist2(p, k);
                    if (bi < 0 || d < best)
                    begin
                        bi = k; best = d;
                    end
                end
                if (bi >= 0)
                    expected_answers.push_back(make_answer(box_t[bi], bi[3:0], 0, 1, 0, 1));
                else
                    expected_answers.push_back(make_answer(0, 0, 0, 0, 0, 1));
            end
            nbrc_pkg::CMD_INFL:
            begin
                hit = 1'b0;
                for (int k = 0; k < box_n && !hit; k++)
                begin
                    if (box_t[k] != c.rtype)
                        continue;
                    mh = ((box_s[k][0] > box_s[k][1]) ? box_s[k][0] : box_s[k][1]) + 2 * blend;
                    d = box_dist2(p, k);
                    if (d <= mh * mh)
                    begin
                        hit = 1'b1;
                        best = (mh == 0) ? 65536 : (65536 * (mh - root_floor(d))) / mh;
                        expected_answers.push_back(
                            make_answer(c.rtype, k[3:0], best[16:0], 1, 0, 1));
                    end
                end
                if (!hit)
                    expected_answers.push_back(make_answer(c.rtype, 0, 0, 0, 0, 1));
            end
            nbrc_pkg::CMD_NEARBY:
            begin
                n = 0;
                lim = 4 * longint'(c.rad) * longint'(c.rad);
                for (int k = 0; k < box_n; k++)
                begin
                    if (box_dist2(p, k) <= lim)
                    begin
                        expected_answers.push_back(make_answer(box_t[k], k[3:0], 0, 1, 0, 0));
                        n++;
                    end
                end
                if (n == 0)
                    expected_answers.push_back(make_answer(0, 0, 0, 0, 0, 1));
                else
                    expected_answers[$].last = 1'b1;
            end
            default:
                expected_answers.push_back(make_answer(0, 0, 0, 0, 0, 1));
        endcase
    endtask

    // Sender: one transaction at a time from the pending queue, with random gaps.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                command_t c;
                c = pending_cmds.pop_front();
                command <= c.cmd; region_type <= c.rtype;
                pos_x <= c.px; pos_y <= c.py; pos_z <= c.pz;
                size_x <= c.sx; size_y <= c.sy; size_z <= c.sz; radius <= c.rad;
                in_valid <= 1'b1;
                if (idling_on && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        command_t c;
        if (rst_n && in_valid && in_ready)
        begin
            c.cmd = command; c.rtype = region_type;
            c.px = pos_x; c.py = pos_y; c.pz = pos_z;
            c.sx = size_x; c.sy = size_y; c.sz = size_z; c.rad = radius;
            classify(c);
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when asked for.
    int take_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_stall <= 0;
        end
        else if (take_stall > 0)
        begin
            out_ready <= 1'b0;
            take_stall <= take_stall - 1;
        end
        else if (long_holds_done < long_holds_asked)
        begin
            out_ready <= 1'b0;
            take_stall <= 400;
            long_holds_done <= long_holds_done + 1;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            take_stall <= $urandom_range(0, 12);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected transaction, type %0d index %0d", $time,
                         result_type, region_index);
                errors++;
            end
            else
            begin
                e = expected_answers.pop_front();
                if ({result_type, region_index, influence, found, table_full, last} !==
                    {e.rtype, e.idx, e.infl, e.found, e.full, e.last})
                begin
                    $display("%0t: mismatch expected type %0d idx %0d infl %0d found %0d full %0d last %0d",
                             $time, e.rtype, e.idx, e.infl, e.found, e.full, e.last);
                    $display("%0t:            actual type %0d idx %0d infl %0d found %0d full %0d last %0d",
                             $time, result_type, region_index, influence, found, table_full,
                             last);
                    errors++;
                end
            end
        end
    end

    task automatic queue_cmd(logic [2:0] cmd, logic [2:0] t, longint x, longint y, longint z,
                             longint unsigned sx, longint unsigned sy, longint unsigned sz,
                             longint unsigned rad);
        command_t c;
        c.cmd = cmd; c.rtype = t; c.px = 20'(x); c.py = 20'(y); c.pz = 20'(z);
        c.sx = 20'(sx); c.sy = 20'(sy); c.sz = 20'(sz); c.rad = 21'(rad);
        pending_cmds.push_back(c);
        if (cmd == nbrc_pkg::CMD_CLEAR)
        begin
            gen_n = 0;
            aim_c.delete();
        end
        else if (cmd == nbrc_pkg::CMD_ADD && gen_n < nbrc_pkg::MAX_REGIONS)
        begin
            aim_c.push_back('{x, y, z});
            gen_n++;
        end
    endtask

    task automatic drain;
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_answers.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_blend(logic [19:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        blend = v;
    endtask

    function automatic longint pick_coord(int a);
        longint base;
        if ($urandom_range(0, 9) == 0)
            return longint'($signed(20'($urandom)));
        base = (aim_c.size() > 0 && $urandom_range(0, 2) != 0)
               ? aim_c[$urandom_range(0, aim_c.size() - 1)][a] : 0;
        base = base + $urandom_range(0, 8000) - 4000;
        if (base > 524287) base = 524287;
        if (base < -524288) base = -524288;
        return base;
    endfunction

    function automatic longint unsigned pick_size();
        return ($urandom_range(0, 9) == 0) ? longint'(20'($urandom))
                                            : longint'($urandom_range(0, 5000));
    endfunction

    task automatic random_cmds(int count);
        int sel;
        logic [2:0] cmd;
        longint unsigned rad;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
                cmd = nbrc_pkg::CMD_CLEAR;
            else if (sel < 6)
                cmd = 3'($urandom_range(5, 7));
            else if (sel < 35 || gen_n < 3)
                cmd = nbrc_pkg::CMD_ADD;
            else if (sel < 55)
                cmd = nbrc_pkg::CMD_NEAREST;
            else if (sel < 78)
                cmd = nbrc_pkg::CMD_INFL;
            else
                cmd = nbrc_pkg::CMD_NEARBY;
            rad = ($urandom_range(0, 7) == 0) ? longint'(21'($urandom))
                                              : longint'($urandom_range(0, 6000));
            queue_cmd(cmd, 3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 2)),
                      pick_coord(0), pick_coord(1), pick_coord(2),
                      pick_size(), pick_size(), pick_size(), rad);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, unknown commands, extremes, a full table, then clear.
        queue_cmd(nbrc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_INFL, 5, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_NEARBY, 0, 0, 0, 0, 0, 0, 0, 2097151);
        queue_cmd(3'd5, 7, -1, -1, -1, 1048575, 1048575, 1048575, 2097151);
        queue_cmd(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(3'd7, 7, 524287, 524287, 524287, 1048575, 1048575, 1048575, 2097151);
        queue_cmd(nbrc_pkg::CMD_ADD, 7, 524287, 524287, 524287, 1048575, 1048575, 1048575, 0);
        queue_cmd(nbrc_pkg::CMD_ADD, 0, -524288, -524288, -524288, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_INFL, 7, -524288, 524287, 0, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_NEARBY, 0, 0, 0, 0, 0, 0, 0, 2097151);
        queue_cmd(nbrc_pkg::CMD_NEARBY, 0, -524288, -524288, -524288, 0, 0, 0, 0);
        // Identical boxes exercise the tie rule; the last add is refused.
        for (int i = 0; i < 15; i++)
            queue_cmd(nbrc_pkg::CMD_ADD, 3'(i), 100, 100, 100, 40, 40, 40, 0);
        queue_cmd(nbrc_pkg::CMD_NEAREST, 0, 100, 300, 100, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_NEARBY, 0, 100, 100, 100, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_NEARBY, 0, 0, 0, 0, 0, 0, 0, 2097151);

        // Zero reach: a box of no size with no blend only matches a point lying on it.
        write_blend(20'd0);
        queue_cmd(nbrc_pkg::CMD_ADD, 3, 10, 20, 30, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_INFL, 3, 10, 20, 30, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_INFL, 3, 11, 20, 30, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_INFL, 4, 10, 20, 30, 0, 0, 0, 0);
        queue_cmd(nbrc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);

        write_blend(20'd3000);
        random_cmds(20);
        // The sender keeps offering while the receiver holds off for a long stretch.
        long_holds_asked = 1;
        random_cmds(10);

        write_blend(20'hFFFFF);
        random_cmds(20);

        write_blend(20'($urandom_range(0, 8000)));
        random_cmds(20);
        drain();
        idling_on = 1'b0;
        random_cmds(15);

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(8 * 1000000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
